[src/brfe_pkg.sv]
// Shared types and constants for the byte ring FIFO engine.
package brfe_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int MIR_W  = ADDR_W + 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    localparam logic [3:0] CMD_WRITE = 4'd0;
    localparam logic [3:0] CMD_READ  = 4'd1;
    localparam logic [3:0] CMD_DRAFT = 4'd2;
    localparam logic [3:0] CMD_PEEK  = 4'd3;
    localparam logic [3:0] CMD_WSKIP = 4'd4;
    localparam logic [3:0] CMD_RSKIP = 4'd5;
    localparam logic [3:0] CMD_CLEAR = 4'd6;
    localparam logic [3:0] CMD_RESET = 4'd7;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOPROG = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_USED,
        S_DECIDE,
        S_EXEC,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic calc_used;
        logic decide;
        logic exec;
        logic load_out;
    } dp_cmd_t;

endpackage

[src/brfe_ctrl.sv]
// Sequencer that steps one request through the datapath and owns the output valid.
module brfe_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output brfe_pkg::dp_cmd_t dp_cmd
);
    import brfe_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_USED;
            S_USED:   state_next = S_DECIDE;
            S_DECIDE: state_next = S_EXEC;
            S_EXEC:   state_next = S_FINISH;
            S_FINISH: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        dp_cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                dp_cmd.load_in = s_valid;
            end
            S_USED:   dp_cmd.calc_used = 1'b1;
            S_DECIDE: dp_cmd.decide = 1'b1;
            S_EXEC:   dp_cmd.exec = 1'b1;
            S_FINISH: dp_cmd.load_out = out_free;
            default:  dp_cmd = '0;
        endcase
    end

    always_comb begin
        if (dp_cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[src/brfe_datapath.sv]
// Pointers, byte store, per-request decision logic and the result register.
module brfe_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  brfe_pkg::dp_cmd_t           dp_cmd,
    input  logic                        cfg_valid,
    input  logic [brfe_pkg::CNT_W-1:0]  cfg_data,
    input  logic [3:0]                  s_command,
    input  logic [7:0]                  s_data_in,
    input  logic [brfe_pkg::ADDR_W-1:0] s_offset,
    input  logic [brfe_pkg::CNT_W-1:0]  s_length,
    output logic [7:0]                  m_data_out,
    output logic [brfe_pkg::CNT_W-1:0]  m_moved,
    output logic [1:0]                  m_status,
    output logic [brfe_pkg::CNT_W-1:0]  m_used_count,
    output logic [brfe_pkg::CNT_W-1:0]  m_free_count
);
    import brfe_pkg::*;

    logic [7:0] mem [DEPTH];

    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  wp_reg, rp_reg;
    logic [CNT_W-1:0]  wp_next, rp_next;

    logic [3:0]        cmd_reg;
    logic [7:0]        din_reg;
    logic [ADDR_W-1:0] off_reg;
    logic [CNT_W-1:0]  len_reg;

    logic [CNT_W-1:0]  used_reg, used_next;
    logic [MIR_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  moved_reg, moved_next;
    logic [1:0]        status_reg, status_next;
    logic              wr_reg, wr_next;
    logic              rd_reg, rd_next;
    logic              advw_reg, advw_next;
    logic              advr_reg, advr_next;
    logic              clr_reg, clr_next;
    logic              rst_reg, rst_next;
    logic [7:0]        rdata_reg;

    logic [7:0]        dout_reg;
    logic [CNT_W-1:0]  mout_reg;
    logic [1:0]        sout_reg;
    logic [CNT_W-1:0]  uout_reg;
    logic [CNT_W-1:0]  fout_reg;

    logic [MIR_W-1:0]  cap_w, cap2_w;
    logic [CNT_W-1:0]  used_c, free_c, used_f;
    logic [MIR_W-1:0]  addr_c, adv_sum, adv_mod;
    logic [CNT_W-1:0]  base_ptr;

    assign cap_w  = MIR_W'(cap_reg);
    assign cap2_w = MIR_W'(cap_reg) << 1;

    // Clamp the written capacity into the legal range.
    always_comb begin
        if (cfg_data == '0) begin
            cap_next = CNT_W'(1);
        end else if (cfg_data > CAP_RESET) begin
            cap_next = CAP_RESET;
        end else begin
            cap_next = cfg_data;
        end
    end

    // Fill level in the mirror space: pointers equal means empty.
    function automatic logic [CNT_W-1:0] fill(input logic [CNT_W-1:0] w,
                                              input logic [CNT_W-1:0] r,
                                              input logic [MIR_W-1:0] c2);
        logic [MIR_W-1:0] t;
        begin
            if (w >= r) begin
                t = MIR_W'(w) - MIR_W'(r);
            end else begin
                t = c2 - (MIR_W'(r) - MIR_W'(w));
            end
            return t[CNT_W-1:0];
        end
    endfunction

    assign used_c   = fill(wp_reg, rp_reg, cap2_w);
    assign free_c   = cap_reg - used_reg;
    assign base_ptr = (cmd_reg == CMD_READ || cmd_reg == CMD_PEEK) ? rp_reg : wp_reg;

    always_comb begin
        pos_next = MIR_W'(base_ptr);
        if (cmd_reg == CMD_DRAFT || cmd_reg == CMD_PEEK) begin
            pos_next = MIR_W'(base_ptr) + MIR_W'(off_reg);
        end
    end

    always_comb begin
        wr_next     = 1'b0;
        rd_next     = 1'b0;
        advw_next   = 1'b0;
        advr_next   = 1'b0;
        clr_next    = 1'b0;
        rst_next    = 1'b0;
        n_next      = CNT_W'(1);
        moved_next  = '0;
        status_next = ST_OK;
        case (cmd_reg)
            CMD_WRITE: begin
                if (free_c == '0) begin
                    status_next = ST_NOPROG;
                end else begin
                    wr_next    = 1'b1;
                    advw_next  = 1'b1;
                    moved_next = CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (used_reg == '0) begin
                    status_next = ST_NOPROG;
                end else begin
                    rd_next    = 1'b1;
                    advr_next  = 1'b1;
                    moved_next = CNT_W'(1);
                end
            end
            CMD_DRAFT: begin
                if (CNT_W'(off_reg) >= free_c) begin
                    status_next = ST_RANGE;
                end else begin
                    wr_next    = 1'b1;
                    moved_next = CNT_W'(1);
                end
            end
            CMD_PEEK: begin
                if (CNT_W'(off_reg) >= used_reg) begin
                    status_next = ST_RANGE;
                end else begin
                    rd_next    = 1'b1;
                    moved_next = CNT_W'(1);
                end
            end
            CMD_WSKIP: begin
                n_next = (len_reg > free_c) ? free_c : len_reg;
                if (n_next == '0) begin
                    status_next = ST_NOPROG;
                end else begin
                    advw_next  = 1'b1;
                    moved_next = n_next;
                end
            end
            CMD_RSKIP: begin
                n_next = (len_reg > used_reg) ? used_reg : len_reg;
                if (n_next == '0) begin
                    status_next = ST_NOPROG;
                end else begin
                    advr_next  = 1'b1;
                    moved_next = n_next;
                end
            end
            CMD_CLEAR: clr_next = 1'b1;
            CMD_RESET: rst_next = 1'b1;
            default:   clr_next = 1'b0;
        endcase
    end

    // The position is below twice the capacity here, so one subtract gives the slot.
    assign addr_c  = (pos_reg >= cap_w) ? pos_reg - cap_w : pos_reg;
    assign adv_sum = MIR_W'(advw_reg ? wp_reg : rp_reg) + MIR_W'(n_reg);
    assign adv_mod = (adv_sum >= cap2_w) ? adv_sum - cap2_w : adv_sum;

    always_comb begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        if (cfg_valid) begin
            wp_next = '0;
            rp_next = '0;
        end else if (dp_cmd.exec) begin
            if (rst_reg) begin
                wp_next = '0;
                rp_next = '0;
            end else if (clr_reg) begin
                rp_next = wp_reg;
            end else if (advw_reg) begin
                wp_next = adv_mod[CNT_W-1:0];
            end else if (advr_reg) begin
                rp_next = adv_mod[CNT_W-1:0];
            end
        end
    end

    assign used_f = fill(wp_reg, rp_reg, cap2_w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
            wp_reg  <= '0;
            rp_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cap_next;
            end
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load_in) begin
            cmd_reg <= s_command;
            din_reg <= s_data_in;
            off_reg <= s_offset;
            len_reg <= s_length;
        end
        if (dp_cmd.calc_used) begin
            used_reg <= used_c;
            pos_reg  <= pos_next;
        end
        if (dp_cmd.decide) begin
            used_reg   <= used_next;
            pos_reg    <= (pos_reg >= cap_w) ? pos_reg - cap_w : pos_reg;
            n_reg      <= n_next;
            moved_reg  <= moved_next;
            status_reg <= status_next;
            wr_reg     <= wr_next;
            rd_reg     <= rd_next;
            advw_reg   <= advw_next;
            advr_reg   <= advr_next;
            clr_reg    <= clr_next;
            rst_reg    <= rst_next;
        end
        if (dp_cmd.load_out) begin
            dout_reg <= rd_reg ? rdata_reg : 8'd0;
            mout_reg <= moved_reg;
            sout_reg <= status_reg;
            uout_reg <= used_f;
            fout_reg <= cap_reg - used_f;
        end
    end

    assign used_next = used_reg;

    always_ff @(posedge aclk) begin
        if (dp_cmd.exec) begin
            if (wr_reg) begin
                mem[addr_c[ADDR_W-1:0]] <= din_reg;
            end
            rdata_reg <= mem[addr_c[ADDR_W-1:0]];
        end
    end

    assign m_data_out   = dout_reg;
    assign m_moved      = mout_reg;
    assign m_status     = sout_reg;
    assign m_used_count = uout_reg;
    assign m_free_count = fout_reg;

endmodule

[src/byte_ring_fifo_engine.sv]
// Top level of the byte ring FIFO engine: sequencer plus datapath.
//
//   Channel   Ports                                         Handshake
//   request   s_command s_data_in s_offset s_length         s_valid / s_ready
//   result    m_data_out m_moved m_status m_used_count      m_valid / m_ready
//             m_free_count
//   config    cfg_data (capacity)                           cfg_valid / cfg_ready
//
// After acceptance a request steps through fill level, decision and first slot fold,
// store access with pointer update, and result load; the sequencer takes no new request
// until that result is loaded. A result waiting on m_ready holds the sequencer in its last
// step; a new request is taken no earlier than the cycle after that result is loaded.
// Reset clears the pointers and the output valid and restores capacity 1024; the result
// register and the store itself are not cleared.
module byte_ring_fifo_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [3:0]                  s_command,
    input  logic [7:0]                  s_data_in,
    input  logic [brfe_pkg::ADDR_W-1:0] s_offset,
    input  logic [brfe_pkg::CNT_W-1:0]  s_length,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_data_out,
    output logic [brfe_pkg::CNT_W-1:0]  m_moved,
    output logic [1:0]                  m_status,
    output logic [brfe_pkg::CNT_W-1:0]  m_used_count,
    output logic [brfe_pkg::CNT_W-1:0]  m_free_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [brfe_pkg::CNT_W-1:0]  cfg_data
);
    import brfe_pkg::*;

    dp_cmd_t dp_cmd;

    assign cfg_ready = 1'b1;

    brfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_cmd  (dp_cmd)
    );

    brfe_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .dp_cmd       (dp_cmd),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .s_command    (s_command),
        .s_data_in    (s_data_in),
        .s_offset     (s_offset),
        .s_length     (s_length),
        .m_data_out   (m_data_out),
        .m_moved      (m_moved),
        .m_status     (m_status),
        .m_used_count (m_used_count),
        .m_free_count (m_free_count)
    );

endmodule

[bench/byte_fifo_checker.sv]
// Watches the byte FIFO channels, predicts every result and compares it with the block's.
module byte_fifo_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [3:0]                  s_command,
    input  logic [7:0]                  s_data_in,
    input  logic [brfe_pkg::ADDR_W-1:0] s_offset,
    input  logic [brfe_pkg::CNT_W-1:0]  s_length,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [7:0]                  m_data_out,
    input  logic [brfe_pkg::CNT_W-1:0]  m_moved,
    input  logic [1:0]                  m_status,
    input  logic [brfe_pkg::CNT_W-1:0]  m_used_count,
    input  logic [brfe_pkg::CNT_W-1:0]  m_free_count,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [brfe_pkg::CNT_W-1:0]  cfg_data,
    output int                          fail_count,
    output int                          outstanding
);
    import brfe_pkg::*;

    typedef struct packed {
        logic [7:0]       data;
        logic [CNT_W-1:0] moved;
        logic [1:0]       status;
        logic [CNT_W-1:0] used;
        logic [CNT_W-1:0] free;
    } fifo_outcome_t;

    fifo_outcome_t    awaited_outcomes[$];
    logic [CNT_W-1:0] cap_setting;
    int unsigned      wr_ptr;
    int unsigned      rd_ptr;
    logic [7:0]       byte_copy [DEPTH];
    int               mismatches = 0;

    function automatic int unsigned occupancy(input int unsigned cap);
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : 2 * cap - (rd_ptr - wr_ptr);
    endfunction

    function automatic fifo_outcome_t fifo_command_outcome(
        input logic [3:0]        cmd,
        input logic [7:0]        din,
        input logic [ADDR_W-1:0] off,
        input logic [CNT_W-1:0]  len
    );
        int unsigned   cap;
        int unsigned   fill;
        int unsigned   room;
        int unsigned   n;
        fifo_outcome_t r;
        // Zero acts as a single entry and anything above the store size as the full store.
        cap = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : cap_setting);
        wr_ptr = wr_ptr % (2 * cap);
        rd_ptr = rd_ptr % (2 * cap);
        fill = occupancy(cap);
        room = cap - fill;
        r = '0;
        case (cmd)
            CMD_WRITE: begin
                if (room == 0) begin
                    r.status = ST_NOPROG;
                end else begin
                    byte_copy[wr_ptr % cap] = din;
                    wr_ptr = (wr_ptr + 1) % (2 * cap);
                    r.moved = CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (fill == 0) begin
                    r.status = ST_NOPROG;
                end else begin
                    r.data = byte_copy[rd_ptr % cap];
                    rd_ptr = (rd_ptr + 1) % (2 * cap);
                    r.moved = CNT_W'(1);
                end
            end
            CMD_DRAFT: begin
                if (off >= room) begin
                    r.status = ST_RANGE;
                end else begin
                    byte_copy[(wr_ptr + off) % cap] = din;
                    r.moved = CNT_W'(1);
                end
            end
            CMD_PEEK: begin
                if (off >= fill) begin
                    r.status = ST_RANGE;
                end else begin
                    r.data = byte_copy[(rd_ptr + off) % cap];
                    r.moved = CNT_W'(1);
                end
            end
            CMD_WSKIP: begin
                n = (len > room) ? room : len;
                if (n == 0) begin
                    r.status = ST_NOPROG;
                end else begin
                    wr_ptr = (wr_ptr + n) % (2 * cap);
                    r.moved = CNT_W'(n);
                end
            end
            CMD_RSKIP: begin
                n = (len > fill) ? fill : len;
                if (n == 0) begin
                    r.status = ST_NOPROG;
                end else begin
                    rd_ptr = (rd_ptr + n) % (2 * cap);
                    r.moved = CNT_W'(n);
                end
            end
            CMD_CLEAR: rd_ptr = wr_ptr;
            CMD_RESET: begin
                wr_ptr = 0;
                rd_ptr = 0;
            end
            default: ;
        endcase
        fill = occupancy(cap);
        r.used = CNT_W'(fill);
        r.free = CNT_W'(cap - fill);
        return r;
    endfunction

    function automatic void compare_field(
        input string       label,
        input logic [15:0] want,
        input logic [15:0] got
    );
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : track
        fifo_outcome_t want;
        if (!aresetn) begin
            cap_setting = CAP_RESET;
            wr_ptr = 0;
            rd_ptr = 0;
            awaited_outcomes.delete();
        end else begin
            // A capacity write restarts the buffer with both pointers at zero.
            if (cfg_valid && cfg_ready) begin
                cap_setting = cfg_data;
                wr_ptr = 0;
                rd_ptr = 0;
            end
            if (s_valid && s_ready) begin
                awaited_outcomes.push_back(
                    fifo_command_outcome(s_command, s_data_in, s_offset, s_length));
            end
            if (m_valid && m_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    $display("%0t: result with no request waiting, data_out %0d moved %0d",
                             $time, m_data_out, m_moved);
                    mismatches++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    compare_field("data_out", 16'(want.data), 16'(m_data_out));
                    compare_field("moved", 16'(want.moved), 16'(m_moved));
                    compare_field("status", 16'(want.status), 16'(m_status));
                    compare_field("used_count", 16'(want.used), 16'(m_used_count));
                    compare_field("free_count", 16'(want.free), 16'(m_free_count));
                end
            end
        end
        fail_count  <= mismatches;
        outstanding <= awaited_outcomes.size();
    end

endmodule

[bench/tb_top.sv]
// Stimulus and verdict for the byte ring FIFO engine, checked by byte_fifo_checker.
module tb_top;
    import brfe_pkg::*;

    localparam logic [3:0] CMD_QUERY   = 4'd8;
    localparam logic [3:0] CMD_UNKNOWN = 4'd15;
    localparam int         PHASES      = 10;
    localparam int         PHASE_ITEMS = 180;
    localparam int         HOLD_AT     = 700;
    localparam int         HOLD_CYCLES = 400;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [3:0]        s_command = '0;
    logic [7:0]        s_data_in = '0;
    logic [ADDR_W-1:0] s_offset  = '0;
    logic [CNT_W-1:0]  s_length  = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [7:0]        m_data_out;
    logic [CNT_W-1:0]  m_moved;
    logic [1:0]        m_status;
    logic [CNT_W-1:0]  m_used_count;
    logic [CNT_W-1:0]  m_free_count;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data  = '0;
    int                fail_count;
    int                outstanding;

    bit                no_gaps     = 1'b0;
    int unsigned       write_share = 30;

    // Fill state kept only to steer the stimulus, toward the live data and away from bytes never written.
    int unsigned track_cap = DEPTH;
    int unsigned track_wr  = 0;
    int unsigned track_rd  = 0;
    bit          slot_written [DEPTH];

    logic [CNT_W-1:0] cap_plan [PHASES] = '{11'd1024, 11'd0, 11'd1, 11'd2, 11'd2047,
                                            11'd3, 11'd17, 11'd513, 11'd100, 11'd1000};

    byte_ring_fifo_engine u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_data_in    (s_data_in),
        .s_offset     (s_offset),
        .s_length     (s_length),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_out   (m_data_out),
        .m_moved      (m_moved),
        .m_status     (m_status),
        .m_used_count (m_used_count),
        .m_free_count (m_free_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    byte_fifo_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_data_in    (s_data_in),
        .s_offset     (s_offset),
        .s_length     (s_length),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_out   (m_data_out),
        .m_moved      (m_moved),
        .m_status     (m_status),
        .m_used_count (m_used_count),
        .m_free_count (m_free_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned track_fill();
        return (track_wr >= track_rd) ? track_wr - track_rd
                                      : 2 * track_cap - (track_rd - track_wr);
    endfunction

    function automatic void track_command(
        input logic [3:0]        cmd,
        input logic [ADDR_W-1:0] off,
        input logic [CNT_W-1:0]  len
    );
        int unsigned fill;
        int unsigned room;
        int unsigned n;
        fill = track_fill();
        room = track_cap - fill;
        case (cmd)
            CMD_WRITE: begin
                if (room != 0) begin
                    slot_written[track_wr % track_cap] = 1'b1;
                    track_wr = (track_wr + 1) % (2 * track_cap);
                end
            end
            CMD_READ:  if (fill != 0) track_rd = (track_rd + 1) % (2 * track_cap);
            CMD_DRAFT: if (off < room) slot_written[(track_wr + off) % track_cap] = 1'b1;
            CMD_WSKIP: begin
                n = (len > room) ? room : len;
                track_wr = (track_wr + n) % (2 * track_cap);
            end
            CMD_RSKIP: begin
                n = (len > fill) ? fill : len;
                track_rd = (track_rd + n) % (2 * track_cap);
            end
            CMD_CLEAR: track_rd = track_wr;
            CMD_RESET: begin
                track_wr = 0;
                track_rd = 0;
            end
            default: ;
        endcase
    endfunction

    task automatic send_request(
        input logic [3:0]        cmd,
        input logic [7:0]        din,
        input logic [ADDR_W-1:0] off,
        input logic [CNT_W-1:0]  len
    );
        int unsigned gap;
        track_command(cmd, off, len);
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_data_in <= din;
        s_offset  <= off;
        s_length  <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random_request();
        logic [3:0]        cmd;
        logic [7:0]        din;
        logic [ADDR_W-1:0] off;
        logic [CNT_W-1:0]  len;
        int unsigned       pick;
        int unsigned       fill;
        int unsigned       room;
        fill = track_fill();
        room = track_cap - fill;
        din  = 8'($urandom);
        off  = ADDR_W'($urandom);
        len  = CNT_W'($urandom);
        pick = $urandom_range(0, 99);
        // Offsets mostly land inside the free space or live data, lengths up to just past it, now and then anywhere.
        if (pick < write_share) begin
            cmd = CMD_WRITE;
        end else if (pick < 55) begin
            cmd = CMD_READ;
        end else if (pick < 65) begin
            cmd = CMD_DRAFT;
            if (room != 0 && $urandom_range(0, 4) != 0) off = ADDR_W'($urandom_range(0, room - 1));
        end else if (pick < 75) begin
            cmd = CMD_PEEK;
            if (fill != 0 && $urandom_range(0, 4) != 0) off = ADDR_W'($urandom_range(0, fill - 1));
        end else if (pick < 82) begin
            cmd = CMD_WSKIP;
            if ($urandom_range(0, 3) != 0) len = CNT_W'($urandom_range(0, room + 2));
        end else if (pick < 89) begin
            cmd = CMD_RSKIP;
            if ($urandom_range(0, 3) != 0) len = CNT_W'($urandom_range(0, fill + 2));
        end else if (pick < 92) begin
            cmd = CMD_CLEAR;
        end else if (pick < 94) begin
            cmd = CMD_RESET;
        end else if (pick < 97) begin
            cmd = CMD_QUERY;
        end else begin
            cmd = 4'($urandom_range(CMD_QUERY + 1, CMD_UNKNOWN));
        end
        // A request that would fetch a byte never stored becomes a plain write.
        if (cmd == CMD_READ && fill != 0 && !slot_written[track_rd % track_cap])
            cmd = CMD_WRITE;
        if (cmd == CMD_PEEK && off < fill && !slot_written[(track_rd + off) % track_cap])
            cmd = CMD_WRITE;
        send_request(cmd, din, off, len);
    endtask

    task automatic wait_quiet();
        int unsigned spins;
        s_valid <= 1'b0;
        spins = 0;
        repeat (2) @(posedge aclk);
        while (outstanding != 0 && spins < 5000) begin
            @(posedge aclk);
            spins++;
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        track_cap = (value == 0) ? 1 : ((value > DEPTH) ? DEPTH : value);
        track_wr  = 0;
        track_rd  = 0;
    endtask

    // Result side: a random stall before each result outside the gap-free phases, and
    // one long hold-off that backs the block up until it refuses new requests.
    initial begin : result_drain
        int unsigned stall;
        int unsigned taken;
        stall = 0;
        taken = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                taken++;
                stall = (taken == HOLD_AT) ? HOLD_CYCLES : (no_gaps ? 0 : $urandom_range(0, 9));
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int unsigned ph;
        int unsigned k;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty buffer: nothing to read, peek or skip.
        send_request(CMD_QUERY, 8'h00, 10'd0, 11'd0);
        send_request(CMD_READ, 8'h00, 10'd0, 11'd0);
        send_request(CMD_PEEK, 8'h00, 10'd0, 11'd0);
        send_request(CMD_RSKIP, 8'h00, 10'd0, 11'd5);
        send_request(CMD_WSKIP, 8'h00, 10'd0, 11'd0);
        send_request(CMD_WRITE, 8'h00, 10'd0, 11'd0);
        send_request(CMD_WRITE, 8'hFF, 10'd0, 11'd0);
        send_request(CMD_WRITE, 8'hA5, 10'd0, 11'd0);
        send_request(CMD_PEEK, 8'h00, 10'd2, 11'd0);
        send_request(CMD_PEEK, 8'h00, 10'd3, 11'd0);
        // Draft writes at the first and last free offsets, then just past the free space.
        send_request(CMD_DRAFT, 8'h5A, 10'd0, 11'd0);
        send_request(CMD_DRAFT, 8'h3C, 10'd1020, 11'd0);
        send_request(CMD_DRAFT, 8'h77, 10'd1021, 11'd0);
        send_request(CMD_DRAFT, 8'h11, 10'd1023, 11'd0);
        send_request(CMD_READ, 8'h00, 10'd0, 11'd0);
        // Oversized skip saturates to the free space and leaves the buffer full.
        send_request(CMD_WSKIP, 8'h00, 10'd0, 11'd2047);
        send_request(CMD_WRITE, 8'h42, 10'd0, 11'd0);
        send_request(CMD_DRAFT, 8'h42, 10'd0, 11'd0);
        send_request(CMD_PEEK, 8'h00, 10'd1023, 11'd0);
        send_request(CMD_RSKIP, 8'h00, 10'd0, 11'd2047);
        send_request(CMD_WRITE, 8'h81, 10'd0, 11'd0);
        send_request(CMD_CLEAR, 8'h00, 10'd0, 11'd0);
        send_request(CMD_RESET, 8'h00, 10'd0, 11'd0);
        send_request(CMD_UNKNOWN, 8'h00, 10'd0, 11'd0);

        for (ph = 0; ph < PHASES; ph++) begin
            wait_quiet();
            no_gaps     = (ph == 3 || ph == 7);
            write_share = (ph % 2 == 0) ? 40 : 25;
            write_capacity(cap_plan[ph]);
            for (k = 0; k < PHASE_ITEMS; k++) send_random_request();
        end
        wait_quiet();

        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin : watchdog
        #10000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

[sim.f]
src/brfe_pkg.sv
src/brfe_ctrl.sv
src/brfe_datapath.sv
src/byte_ring_fifo_engine.sv
bench/byte_fifo_checker.sv
bench/tb_top.sv
